@@ rtl/rainbow_led_pattern_generator_unit_assert.svh @@
// Assertion macros used by the top level of the rainbow pattern generator RTL.
`ifndef RAINBOW_LED_PATTERN_GENERATOR_UNIT_ASSERT_SVH
`define RAINBOW_LED_PATTERN_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RLPG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlpg: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RLPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlpg: next-cycle check failed");

`endif

@@ rtl/rlpg_pkg.sv @@
// Types, constants and shared helpers of the rainbow pattern generator.
package rlpg_pkg;

  // Number of LEDs driven per frame and the width of the LED counter.
  localparam int NUM_LEDS  = 16;
  localparam int LED_CNT_W = (NUM_LEDS > 16) ? $clog2(NUM_LEDS) : 4;
  localparam logic [LED_CNT_W-1:0] LAST_LED = LED_CNT_W'(NUM_LEDS - 1);
  localparam logic [3:0] LAST_IDX = 4'((NUM_LEDS - 1) % 16);

  // Depth of the frame command queue; the pointers are one bit wide.
  localparam int QDEPTH = 2;

  // Field and register widths.
  localparam int HUE_W      = 9;
  localparam int FD_W       = 8;
  localparam int BR_W       = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int PROD_W     = 14;
  localparam int REM_W      = 6;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DIVIDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LED_SPACING   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS    = 3'd3;

  // Hue circle and sector constants.
  localparam logic [HUE_W:0]   FULL_CIRCLE = 10'd360;
  localparam logic [REM_W-1:0] SECTOR_SPAN = 6'd60;

  // floor(x / 60) for x below 23831 is (x * 17477) >> 20.
  localparam logic [14:0] RECIP_60    = 15'd17477;
  localparam int          RECIP_SHIFT = 20;

  // Hue sectors of sixty degrees each.
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  // Configuration register set.
  typedef struct packed {
    logic [FD_W-1:0]  frame_divider;
    logic [HUE_W-1:0] hue_step;
    logic [HUE_W-1:0] led_spacing;
    logic [BR_W-1:0]  brightness;
  } cfg_t;

  // Frame command handed from the front to the queue.
  typedef struct packed {
    logic             valid;
    logic [HUE_W-1:0] offset;
  } push_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Adds a step of up to 511 degrees to a hue below 360, modulo 360.
  function automatic logic [HUE_W-1:0] wrap_add(input logic [HUE_W-1:0] hue,
                                                input logic [HUE_W-1:0] step);
    logic [HUE_W:0] step_m;
    logic [HUE_W:0] sum;
    step_m = {1'b0, step};
    if (step_m >= FULL_CIRCLE) begin
      step_m = step_m - FULL_CIRCLE;
    end
    sum = {1'b0, hue} + step_m;
    if (sum >= FULL_CIRCLE) begin
      sum = sum - FULL_CIRCLE;
    end
    return sum[HUE_W-1:0];
  endfunction

endpackage

@@ rtl/rainbow_led_pattern_generator_unit.sv @@
// Top level of the rainbow LED pattern generator: configuration, front, queue, back.
// A tick that completes a frame is taken and its command queued; the sixteen colours of the
// frame follow one per cycle through the five-stage colour pipeline while the sink is ready.
// The LED sequencer takes the next command from the queue in its idle state between frames.
// Ticks are taken every cycle while the two-entry frame queue has room.
// Synchronous active-low reset restores the register defaults and clears counts and offset.
module rainbow_led_pattern_generator_unit
  import rlpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] tick, [7:1] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [3:0] led_index, [11:4] red, [19:12] green,
                                            // [27:20] blue, [31:28] zero
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t             cfg_r, cfg_nxt;
  push_t            push;
  qstat_t           qstat;
  logic [HUE_W-1:0] head;
  logic             pop;
  logic             in_xfer;

  // Configuration register writes; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_DIVIDER: cfg_nxt.frame_divider = cfg_wdata[FD_W-1:0];
        REG_HUE_STEP:      cfg_nxt.hue_step      = cfg_wdata[HUE_W-1:0];
        REG_LED_SPACING:   cfg_nxt.led_spacing   = cfg_wdata[HUE_W-1:0];
        REG_BRIGHTNESS:    cfg_nxt.brightness    = cfg_wdata[BR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_divider <= 8'd5;
      cfg_r.hue_step      <= 9'd10;
      cfg_r.led_spacing   <= 9'd22;
      cfg_r.brightness    <= 8'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input transfers are taken whenever the queue has room.
  assign in_tready = !qstat.full;
  assign in_xfer   = in_tvalid && in_tready;

  rlpg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_xfer (in_xfer),
    .in_tick (in_tdata[0]),
    .cfg     (cfg_r),
    .push    (push)
  );

  rlpg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  rlpg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .qstat      (qstat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Checks on the block's own logic.
  `include "rainbow_led_pattern_generator_unit_assert.svh"

  `RLPG_ASSERT_IMPL(a_no_overflow, push.valid, !qstat.full)
  `RLPG_ASSERT_NEXT(a_push_kept, push.valid && !pop, !qstat.empty)
  `RLPG_ASSERT_IMPL(a_last_index, out_tvalid && out_tlast, out_tdata[3:0] == LAST_IDX)
  `RLPG_ASSERT_IMPL(a_channel_max, out_tvalid,
                    (out_tdata[11:4] <= cfg_r.brightness) &&
                    (out_tdata[19:12] <= cfg_r.brightness) &&
                    (out_tdata[27:20] <= cfg_r.brightness))

endmodule

@@ rtl/rlpg_front.sv @@
// Front end: counts ticks, decides when a frame is due and issues frame commands.
module rlpg_front
  import rlpg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_xfer,
  input  logic  in_tick,
  input  cfg_t  cfg,
  output push_t push
);

  logic [FD_W-1:0]  tick_count_r, tick_count_nxt;
  logic [HUE_W-1:0] hue_offset_r, hue_offset_nxt;
  logic [FD_W-1:0]  count_inc;
  logic             frame_due;

  // A frame is due once the incremented count reaches the divider.
  assign count_inc = tick_count_r + 8'd1;
  assign frame_due = in_xfer && in_tick && (count_inc >= cfg.frame_divider);

  always_comb begin
    tick_count_nxt = tick_count_r;
    hue_offset_nxt = hue_offset_r;
    if (in_xfer && in_tick) begin
      if (frame_due) begin
        tick_count_nxt = '0;
        hue_offset_nxt = wrap_add(hue_offset_r, cfg.hue_step);
      end else begin
        tick_count_nxt = count_inc;
      end
    end
  end

  // The frame command carries the offset in force before the advance.
  assign push.valid  = frame_due;
  assign push.offset = hue_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      hue_offset_r <= '0;
    end else begin
      tick_count_r <= tick_count_nxt;
      hue_offset_r <= hue_offset_nxt;
    end
  end

endmodule

@@ rtl/rlpg_queue.sv @@
// Two-entry queue of frame commands between the front and the back end.
module rlpg_queue
  import rlpg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  push_t            push,
  input  logic             pop,
  output logic [HUE_W-1:0] head,
  output qstat_t           qstat
);

  logic [HUE_W-1:0] slot_r [QDEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign qstat.full  = (count_r == 2'(QDEPTH));
  assign qstat.empty = (count_r == 2'd0);
  assign do_push     = push.valid && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slot_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.offset;
    end
  end

endmodule

@@ rtl/rlpg_back.sv @@
// Back end: walks the LEDs of one frame and converts each hue to a colour.
module rlpg_back
  import rlpg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  qstat_t           qstat,
  input  logic [HUE_W-1:0] head,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [HUE_W-1:0]       deg_r, deg_nxt;
  logic [LED_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   adv;

  // Stage 1: hue of the LED.
  logic                   s1_v_r;
  logic [HUE_W-1:0]       s1_deg_r;
  logic [3:0]             s1_idx_r;
  logic                   s1_last_r;
  // Stage 2: sector and remainder.
  logic                   s2_v_r;
  sector_t                s2_sec_r;
  logic [REM_W-1:0]       s2_rem_r;
  logic [3:0]             s2_idx_r;
  logic                   s2_last_r;
  // Stage 3: scaled products.
  logic                   s3_v_r;
  sector_t                s3_sec_r;
  logic [PROD_W-1:0]      s3_rise_p_r;
  logic [PROD_W-1:0]      s3_fall_p_r;
  logic [3:0]             s3_idx_r;
  logic                   s3_last_r;
  // Stage 4: divided by sixty.
  logic                   s4_v_r;
  sector_t                s4_sec_r;
  logic [BR_W-1:0]        s4_rise_r;
  logic [BR_W-1:0]        s4_fall_r;
  logic [3:0]             s4_idx_r;
  logic                   s4_last_r;
  // Output register.
  logic                   out_v_r;
  logic [3:0]             out_idx_r;
  logic [BR_W-1:0]        out_red_r;
  logic [BR_W-1:0]        out_grn_r;
  logic [BR_W-1:0]        out_blu_r;
  logic                   out_last_r;

  sector_t                sec_nxt;
  logic [HUE_W-1:0]       sec_base;
  logic [HUE_W-1:0]       rem_full;
  logic [REM_W-1:0]       fall_w;
  logic [28:0]            rise_q;
  logic [28:0]            fall_q;
  logic [BR_W-1:0]        red_nxt, grn_nxt, blu_nxt;

  // The whole pipeline moves unless a result waits for the sink.
  assign adv = !out_v_r || out_tready;

  // LED sequencer: takes a frame command and steps through the LEDs.
  always_comb begin
    state_nxt = state_r;
    deg_nxt   = deg_r;
    cnt_nxt   = cnt_r;
    pop       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          pop       = 1'b1;
          deg_nxt   = head;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv) begin
          deg_nxt = wrap_add(deg_r, cfg.led_spacing);
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == LAST_LED) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deg_r <= deg_nxt;
    cnt_r <= cnt_nxt;
  end

  // Sector search over the six sixty-degree spans.
  always_comb begin
    if (s1_deg_r >= 9'd300) begin
      sec_nxt  = SEC_MAGENTA;
      sec_base = 9'd300;
    end else if (s1_deg_r >= 9'd240) begin
      sec_nxt  = SEC_BLUE;
      sec_base = 9'd240;
    end else if (s1_deg_r >= 9'd180) begin
      sec_nxt  = SEC_CYAN;
      sec_base = 9'd180;
    end else if (s1_deg_r >= 9'd120) begin
      sec_nxt  = SEC_GREEN;
      sec_base = 9'd120;
    end else if (s1_deg_r >= 9'd60) begin
      sec_nxt  = SEC_YELLOW;
      sec_base = 9'd60;
    end else begin
      sec_nxt  = SEC_RED;
      sec_base = 9'd0;
    end
    rem_full = s1_deg_r - sec_base;
  end

  assign fall_w = SECTOR_SPAN - s2_rem_r;

  // Division by sixty through the reciprocal.
  assign rise_q = 29'(s3_rise_p_r) * 29'(RECIP_60);
  assign fall_q = 29'(s3_fall_p_r) * 29'(RECIP_60);

  // Channel selection by sector.
  always_comb begin
    red_nxt = '0;
    grn_nxt = '0;
    blu_nxt = '0;
    case (s4_sec_r)
      SEC_RED: begin
        red_nxt = cfg.brightness;
        grn_nxt = s4_rise_r;
      end
      SEC_YELLOW: begin
        red_nxt = s4_fall_r;
        grn_nxt = cfg.brightness;
      end
      SEC_GREEN: begin
        grn_nxt = cfg.brightness;
        blu_nxt = s4_rise_r;
      end
      SEC_CYAN: begin
        grn_nxt = s4_fall_r;
        blu_nxt = cfg.brightness;
      end
      SEC_BLUE: begin
        red_nxt = s4_rise_r;
        blu_nxt = cfg.brightness;
      end
      default: begin
        red_nxt = cfg.brightness;
        blu_nxt = s4_fall_r;
      end
    endcase
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= (state_r == ST_RUN);
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r;
    end
  end

  // Payload of the pipeline.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_deg_r    <= deg_r;
      s1_idx_r    <= cnt_r[3:0];
      s1_last_r   <= (cnt_r == LAST_LED);
      s2_sec_r    <= sec_nxt;
      s2_rem_r    <= rem_full[REM_W-1:0];
      s2_idx_r    <= s1_idx_r;
      s2_last_r   <= s1_last_r;
      s3_sec_r    <= s2_sec_r;
      s3_rise_p_r <= PROD_W'(s2_rem_r) * PROD_W'(cfg.brightness);
      s3_fall_p_r <= PROD_W'(fall_w) * PROD_W'(cfg.brightness);
      s3_idx_r    <= s2_idx_r;
      s3_last_r   <= s2_last_r;
      s4_sec_r    <= s3_sec_r;
      s4_rise_r   <= rise_q[RECIP_SHIFT +: BR_W];
      s4_fall_r   <= fall_q[RECIP_SHIFT +: BR_W];
      s4_idx_r    <= s3_idx_r;
      s4_last_r   <= s3_last_r;
      out_idx_r   <= s4_idx_r;
      out_red_r   <= red_nxt;
      out_grn_r   <= grn_nxt;
      out_blu_r   <= blu_nxt;
      out_last_r  <= s4_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, out_blu_r, out_grn_r, out_red_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule

@@ tb/rainbow_led_pattern_generator_unit_tb.sv @@
// Self-checking testbench of the rainbow LED pattern generator: ticks in, LED colours checked.
module rainbow_led_pattern_generator_unit_tb
  import rlpg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // First index past the four registers; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
  // Cycles the colour pipeline may still be busy after the last transfer.
  localparam int DRAIN_CYCLES = 32;

  typedef struct packed {
    logic [3:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } led_colour_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'h00;   // [0] tick, [7:1] zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;          // [3:0] led_index, [11:4] red, [19:12] green,
                                             // [27:20] blue, [31:28] zero
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Ticks waiting to be driven and colours waiting to be seen.
  logic        tick_q[$];
  led_colour_t led_colour_q[$];

  // Own copy of the registers and the frame state.
  logic [FD_W-1:0]  frame_div = 8'd5;
  logic [HUE_W-1:0] hue_step = 9'd10;
  logic [HUE_W-1:0] led_spacing = 9'd22;
  logic [BR_W-1:0]  brightness = 8'd10;
  logic [7:0]       tick_cnt = 8'd0;
  logic [HUE_W-1:0] hue_off = 9'd0;

  int in_idle_max = 0;
  int out_idle_max = 0;
  int in_wait = 0;
  int out_stall = 0;
  int out_draw;
  int mismatches = 0;

  rainbow_led_pattern_generator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Advances the tick count and, when a frame is due, queues its sixteen colours.
  task automatic predict_frame(input logic tick);
    logic [7:0]  next_cnt;
    int          deg;
    int          rem;
    int          rise;
    int          fall;
    int          b;
    sector_t     sec;
    led_colour_t c;
    if (!tick) begin
      return;
    end
    next_cnt = tick_cnt + 8'd1;
    if (next_cnt < frame_div) begin
      tick_cnt = next_cnt;
      return;
    end
    tick_cnt = 8'd0;
    b = int'(brightness);
    for (int n = 0; n < NUM_LEDS; n++) begin
      deg  = (n * int'(led_spacing) + int'(hue_off)) % 360;
      sec  = sector_t'(deg / 60);
      rem  = deg % 60;
      rise = (rem * b) / 60;
      fall = ((60 - rem) * b) / 60;
      c.led_index = 4'(n);
      c.frame_end = (n == NUM_LEDS - 1);
      case (sec)
        SEC_RED: begin
          c.red = 8'(b); c.green = 8'(rise); c.blue = 8'd0;
        end
        SEC_YELLOW: begin
          c.red = 8'(fall); c.green = 8'(b); c.blue = 8'd0;
        end
        SEC_GREEN: begin
          c.red = 8'd0; c.green = 8'(b); c.blue = 8'(rise);
        end
        SEC_CYAN: begin
          c.red = 8'd0; c.green = 8'(fall); c.blue = 8'(b);
        end
        SEC_BLUE: begin
          c.red = 8'(rise); c.green = 8'd0; c.blue = 8'(b);
        end
        default: begin
          c.red = 8'(b); c.green = 8'd0; c.blue = 8'(fall);
        end
      endcase
      led_colour_q.push_back(c);
    end
    hue_off = 9'((int'(hue_off) + int'(hue_step)) % 360);
  endtask

  // Reports one field that differs from the prediction.
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Input driver: one tick per transfer, with a random gap drawn per item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_wait > 0) begin
        in_wait   <= in_wait - 1;
        in_tvalid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        in_tdata  <= {7'b0, tick_q.pop_front()};
        in_tvalid <= 1'b1;
        in_wait   <= $urandom_range(0, in_idle_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result back-pressure: after each transfer the sink stalls for a random number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      out_draw   = $urandom_range(0, out_idle_max);
      out_stall  <= out_draw;
      out_tready <= (out_draw == 0);
    end else if (out_stall > 0) begin
      out_stall  <= out_stall - 1;
      out_tready <= (out_stall == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predicts on each accepted tick and checks each accepted colour.
  always @(posedge clk) begin : monitor
    led_colour_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_frame(in_tdata[0]);
      end
      if (out_tvalid && out_tready) begin
        if (led_colour_q.size() == 0) begin
          $display("%0t: unexpected colour transfer, got %h last %b", $time, out_tdata,
                   out_tlast);
          mismatches++;
        end else begin
          want = led_colour_q.pop_front();
          check_field("led_index", want.led_index, out_tdata[3:0]);
          check_field("red", want.red, out_tdata[11:4]);
          check_field("green", want.green, out_tdata[19:12]);
          check_field("blue", want.blue, out_tdata[27:20]);
          check_field("frame_end", want.frame_end, out_tlast);
        end
      end
    end
  end

  // Writes one register and mirrors it in the model; only called while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FRAME_DIVIDER: frame_div   = val[FD_W-1:0];
      REG_HUE_STEP:      hue_step    = val;
      REG_LED_SPACING:   led_spacing = val;
      REG_BRIGHTNESS:    brightness  = val[BR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input int fd, input int hs, input int sp, input int br);
    write_reg(REG_FRAME_DIVIDER, CFG_DATA_W'(fd));
    write_reg(REG_HUE_STEP, CFG_DATA_W'(hs));
    write_reg(REG_LED_SPACING, CFG_DATA_W'(sp));
    write_reg(REG_BRIGHTNESS, CFG_DATA_W'(br));
  endtask

  // Picks how hard each side idles for the coming phase.
  task automatic pick_idling();
    int modes[3];
    modes = '{0, 3, 15};
    in_idle_max  = modes[$urandom_range(0, 2)];
    out_idle_max = modes[$urandom_range(0, 2)];
  endtask

  // Queues ticks away from the clock edge; pct_one is the share of ticks that are 1.
  task automatic add_ticks(input int count, input int pct_one);
    @(negedge clk);
    repeat (count) begin
      tick_q.push_back($urandom_range(0, 99) < pct_one);
    end
  endtask

  // Waits until every tick is sent and every colour seen, then lets the pipeline drain.
  task automatic wait_idle();
    @(negedge clk);
    while (tick_q.size() != 0 || in_tvalid || led_colour_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random pick of a hue register, with a bias towards the edges of the circle.
  function automatic int pick_degrees();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 359;
      2: return 360;
      3: return 511;
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  // Stimulus: directed phases, then random phases with fresh settings.
  initial begin : stimulus
    int fd;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults, an idle input on either side of one frame.
    pick_idling();
    add_ticks(1, 0);
    add_ticks(5, 100);
    add_ticks(1, 0);
    wait_idle();

    // Divider lowered below a count already reached.
    add_ticks(4, 100);
    wait_idle();
    write_reg(REG_FRAME_DIVIDER, 9'd2);
    add_ticks(1, 100);
    wait_idle();

    // Largest values, a divider of zero and an ignored register index.
    pick_idling();
    set_regs(0, 511, 359, 255);
    write_reg(REG_SPARE_FIRST, 9'h1ff);
    add_ticks(3, 100);
    wait_idle();

    // Zero everywhere but a divider of one.
    set_regs(1, 0, 0, 0);
    write_reg(REG_SPARE_FIRST + 3'd3, 9'h000);
    add_ticks(2, 100);
    wait_idle();

    // A full circle between neighbours, so every LED shares one hue.
    pick_idling();
    set_regs(2, 359, 360, 128);
    add_ticks(4, 100);
    wait_idle();

    // Random phases.
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 9))
        0: fd = 0;
        1: fd = 255;
        2: fd = $urandom_range(7, 255);
        default: fd = $urandom_range(1, 6);
      endcase
      pick_idling();
      set_regs(fd, pick_degrees(), pick_degrees(), $urandom_range(0, 255));
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_SPARE_FIRST + 3'($urandom_range(0, 3)), 9'($urandom_range(0, 511)));
      end
      add_ticks($urandom_range(15, 35), 85);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("rainbow_led_pattern_generator_unit regression: pass");
    end else begin
      $display("rainbow_led_pattern_generator_unit regression: fail");
    end
    $finish;
  end

  // Watchdog for a block that stops responding.
  initial begin : watchdog
    #5_000_000;
    $display("rainbow_led_pattern_generator_unit regression: fail");
    $finish;
  end

endmodule
